>>> rtl/core/dsp_pkg.sv
`default_nettype none

package dsp_pkg;

    // field widths of the channels and the register
    localparam int KIND_W        = 2;
    localparam int SLOT_FIELD_W  = 5;
    localparam int COUNT_FIELD_W = 6;
    localparam int TOTAL_W       = 7;

    // register reset value and the cap on reported slots per sweep
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 7'd64;
    localparam int MAX_RESULTS = 32;

    // command queue between the front and the back
    localparam int QUEUE_DEPTH = 2;

    // input kind codes
    localparam logic [KIND_W-1:0] KIND_SPAWN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RETIRE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SWEEP  = 2'd2;

    // decoded operation
    typedef enum logic [1:0] {
        OP_SPAWN  = 2'd0,
        OP_RETIRE = 2'd1,
        OP_SWEEP  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic                    side;
        logic [SLOT_FIELD_W-1:0] slot;
    } cmd_t;

    // front to queue
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_push_t;

    // queue to back
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

endpackage

`default_nettype wire

>>> rtl/core/dsp_if.sv
`default_nettype none

// request channel: one beat per command
interface dsp_req_if import dsp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic                    side;
    logic [SLOT_FIELD_W-1:0] slot;

    modport source (output valid, output kind, output side, output slot, input ready);
    modport sink   (input valid, input kind, input side, input slot, output ready);
endinterface

// response channel: one beat per result
interface dsp_rsp_if import dsp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic [SLOT_FIELD_W-1:0]  slot_index;
    logic                     pool_side;
    logic [COUNT_FIELD_W-1:0] active_count;
    logic                     last;

    modport source (output valid, output ok, output slot_index, output pool_side,
                    output active_count, output last, input ready);
    modport sink   (input valid, input ok, input slot_index, input pool_side,
                    input active_count, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/dual_slot_pool_allocator.sv
`default_nettype none

// channel   dir  handshake        payload
// req       in   valid / ready    kind, side, slot
// rsp       out  valid / ready    ok, slot_index, pool_side, active_count, last
// cfg       in   cfg_we           cfg_wdata (total capacity)
//
// spawn runs the idle, spawn and spawn-finish states, retire the idle and single states, after
// the front stage and queue. sweep reads and checks each entry, moving the tail into dead ones,
// then reads and reports each slot, paced by the single read port of the active list memory.
// reset and capacity writes take effect at once; next-free links carry valid bits.
// a 2-deep command queue and the result register let each side stall on its own.
module dual_slot_pool_allocator import dsp_pkg::*; #(
    parameter int POOL_SLOTS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [TOTAL_W-1:0] cfg_wdata,
    dsp_req_if.sink                 req,
    dsp_rsp_if.source               rsp
);

    q_push_t push;
    q_head_t head;
    logic    q_full;
    logic    pop;

    // accept and classify
    dsp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .q_full (q_full),
        .push   (push)
    );

    // decoupling queue
    dsp_cmd_fifo u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    // pool state and execution
    dsp_back #(.POOL_SLOTS(POOL_SLOTS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .head      (head),
        .pop       (pop),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

>>> rtl/core/dsp_ram.sv
`default_nettype none

module dsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/dsp_front.sv
`default_nettype none

module dsp_front import dsp_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    dsp_req_if.sink   req,
    input  wire logic q_full,
    output q_push_t   push
);

    logic stg_valid_reg;
    logic stg_valid_next;
    cmd_t stg_cmd_reg;
    cmd_t stg_cmd_next;
    logic take;
    logic drain;
    op_t  op_dec;

    // classify the incoming kind
    always_comb
    begin
        unique case (req.kind)
            KIND_SPAWN:  op_dec = OP_SPAWN;
            KIND_RETIRE: op_dec = OP_RETIRE;
            KIND_SWEEP:  op_dec = OP_SWEEP;
            default:     op_dec = OP_NOP;
        endcase
    end

    // one staging register ahead of the queue
    assign drain     = stg_valid_reg && !q_full;
    assign req.ready = !stg_valid_reg || !q_full;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        stg_cmd_next   = stg_cmd_reg;
        if (take)
        begin
            stg_valid_next    = 1'b1;
            stg_cmd_next.op   = op_dec;
            stg_cmd_next.side = req.side;
            stg_cmd_next.slot = req.slot;
        end
        else if (drain)
        begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stg_cmd_reg <= stg_cmd_next;
    end

    assign push.valid = stg_valid_reg;
    assign push.cmd   = stg_cmd_reg;

endmodule

`default_nettype wire

>>> rtl/core/dsp_cmd_fifo.sv
`default_nettype none

module dsp_cmd_fifo import dsp_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire q_push_t push,
    output logic         full,
    output q_head_t      head,
    input  wire logic    pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/dsp_back.sv
`default_nettype none

module dsp_back import dsp_pkg::*; #(
    parameter int POOL_SLOTS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [TOTAL_W-1:0] cfg_wdata,
    input  wire q_head_t            head,
    output logic                    pop,
    dsp_rsp_if.source               rsp
);

    localparam int SLOT_W    = $clog2(POOL_SLOTS);
    localparam int CNT_W     = $clog2(POOL_SLOTS + 1);
    localparam int ADDR_W    = SLOT_W + 1;
    localparam int RAM_DEPTH = 2 ** ADDR_W;
    localparam int NF_W      = SLOT_W + 1;
    localparam int KW        = CNT_W + 1;
    localparam int SUM_W     = $clog2(2 * POOL_SLOTS + 1);
    localparam int CAPW      = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;
    localparam int RW        = (CNT_W > SLOT_FIELD_W) ? CNT_W : SLOT_FIELD_W;

    // split the total capacity between the two pools
    function automatic logic [2*CNT_W-1:0] split_cap(input logic [TOTAL_W-1:0] tc);
        logic [CAPW-1:0] c;
        logic [CAPW-1:0] c0;
        c = CAPW'(tc);
        if (c > CAPW'(2 * POOL_SLOTS))
        begin
            c = CAPW'(2 * POOL_SLOTS);
        end
        c0 = c >> 1;
        return {CNT_W'(c - c0), CNT_W'(c0)};
    endfunction

    localparam logic [2*CNT_W-1:0] CAP_RST = split_cap(TOTAL_RESET);

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b0000000001,
        ST_SPAWN     = 10'b0000000010,
        ST_SPAWN_FIN = 10'b0000000100,
        ST_SINGLE    = 10'b0000001000,
        ST_W_RD      = 10'b0000010000,
        ST_W_CHK     = 10'b0000100000,
        ST_W_MV      = 10'b0001000000,
        ST_E_RD      = 10'b0010000000,
        ST_E_OUT     = 10'b0100000000,
        ST_SPARE     = 10'b1000000000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    cmd_t                 cmd_reg;
    cmd_t                 cmd_next;
    logic [CNT_W-1:0]     cap_reg [2];
    logic [CNT_W-1:0]     cap_next [2];
    logic [SLOT_W-1:0]    fh_reg [2];
    logic [SLOT_W-1:0]    fh_next [2];
    logic                 he_reg [2];
    logic                 he_next [2];
    logic [CNT_W-1:0]     len_reg [2];
    logic [CNT_W-1:0]     len_next [2];
    logic [RAM_DEPTH-1:0] alive_reg;
    logic [RAM_DEPTH-1:0] alive_next;
    logic [RAM_DEPTH-1:0] nfv_reg;
    logic [RAM_DEPTH-1:0] nfv_next;
    logic [CNT_W-1:0]     i_reg;
    logic [CNT_W-1:0]     i_next;
    logic [SLOT_W-1:0]    spawn_idx_reg;
    logic [SLOT_W-1:0]    spawn_idx_next;
    logic                 nf_hit_reg;
    logic                 nf_hit_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 ok_reg;
    logic                 ok_next;
    logic [SLOT_FIELD_W-1:0]  slot_out_reg;
    logic [SLOT_FIELD_W-1:0]  slot_out_next;
    logic                     side_out_reg;
    logic                     side_out_next;
    logic [COUNT_FIELD_W-1:0] count_out_reg;
    logic [COUNT_FIELD_W-1:0] count_out_next;
    logic                     last_reg;
    logic                     last_next;

    // ram ports
    logic              list_we;
    logic [ADDR_W-1:0] list_wa;
    logic [SLOT_W-1:0] list_wd;
    logic              list_re;
    logic [ADDR_W-1:0] list_ra;
    logic [SLOT_W-1:0] list_rd;
    logic              nf_we;
    logic [ADDR_W-1:0] nf_wa;
    logic [NF_W-1:0]   nf_wd;
    logic              nf_re;
    logic [ADDR_W-1:0] nf_ra;
    logic [NF_W-1:0]   nf_rd;

    // working views of the addressed pool
    logic              s;
    logic [CNT_W-1:0]  cur_len;
    logic [CNT_W-1:0]  cur_cap;
    logic [SLOT_W-1:0] cur_fh;
    logic              cur_he;
    logic              can_load;
    logic              spawn_fail;
    logic              retire_hit;
    logic [CNT_W-1:0]  nxt_cnt;
    logic              fb_more;
    logic [KW-1:0]     k_inc;
    logic              emit_last;
    logic [CNT_W-1:0]  len_dec;
    logic [ADDR_W-1:0] idx_addr;
    logic [2*CNT_W-1:0] cfg_caps;

    dsp_ram #(.WIDTH(SLOT_W), .DEPTH(RAM_DEPTH)) u_list_ram (
        .clk     (clk),
        .wr_en   (list_we),
        .wr_addr (list_wa),
        .wr_data (list_wd),
        .rd_en   (list_re),
        .rd_addr (list_ra),
        .rd_data (list_rd)
    );

    dsp_ram #(.WIDTH(NF_W), .DEPTH(RAM_DEPTH)) u_next_free_ram (
        .clk     (clk),
        .wr_en   (nf_we),
        .wr_addr (nf_wa),
        .wr_data (nf_wd),
        .rd_en   (nf_re),
        .rd_addr (nf_ra),
        .rd_data (nf_rd)
    );

    assign s          = cmd_reg.side;
    assign cur_len    = len_reg[s];
    assign cur_cap    = cap_reg[s];
    assign cur_fh     = fh_reg[s];
    assign cur_he     = he_reg[s];
    assign can_load   = !out_valid_reg || rsp.ready;
    assign spawn_fail = cur_he || (cur_len >= CNT_W'(POOL_SLOTS));
    assign retire_hit = (RW'(cmd_reg.slot) < RW'(cur_cap))
                        && alive_reg[{s, SLOT_W'(cmd_reg.slot)}];
    assign nxt_cnt    = CNT_W'(spawn_idx_reg) + CNT_W'(1);
    assign fb_more    = nxt_cnt < cur_cap;
    assign k_inc      = {1'b0, i_reg} + KW'(1);
    assign emit_last  = (k_inc == {1'b0, cur_len}) || (k_inc == KW'(MAX_RESULTS));
    assign len_dec    = cur_len - CNT_W'(1);
    assign idx_addr   = {s, list_rd};
    assign cfg_caps   = split_cap(cfg_wdata);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cap_next       = cap_reg;
        fh_next        = fh_reg;
        he_next        = he_reg;
        len_next       = len_reg;
        alive_next     = alive_reg;
        nfv_next       = nfv_reg;
        i_next         = i_reg;
        spawn_idx_next = spawn_idx_reg;
        nf_hit_next    = nf_hit_reg;
        out_valid_next = rsp.ready ? 1'b0 : out_valid_reg;
        ok_next        = ok_reg;
        slot_out_next  = slot_out_reg;
        side_out_next  = side_out_reg;
        count_out_next = count_out_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        list_we        = 1'b0;
        list_wa        = '0;
        list_wd        = '0;
        list_re        = 1'b0;
        list_ra        = '0;
        nf_we          = 1'b0;
        nf_wa          = '0;
        nf_wd          = '0;
        nf_re          = 1'b0;
        nf_ra          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop      = 1'b1;
                    cmd_next = head.cmd;
                    i_next   = '0;
                    unique case (head.cmd.op)
                        OP_SPAWN: state_next = ST_SPAWN;
                        OP_SWEEP: state_next = ST_W_RD;
                        default:  state_next = ST_SINGLE;
                    endcase
                end
            end

            // pop the free head, append to the active list
            ST_SPAWN:
            begin
                if (spawn_fail)
                begin
                    state_next = ST_SINGLE;
                end
                else
                begin
                    list_we                 = 1'b1;
                    list_wa                 = {s, cur_len[SLOT_W-1:0]};
                    list_wd                 = cur_fh;
                    nf_re                   = 1'b1;
                    nf_ra                   = {s, cur_fh};
                    nf_hit_next             = nfv_reg[{s, cur_fh}];
                    spawn_idx_next          = cur_fh;
                    alive_next[{s, cur_fh}] = 1'b1;
                    len_next[s]             = cur_len + CNT_W'(1);
                    state_next              = ST_SPAWN_FIN;
                end
            end

            // advance the free head, unwritten links follow slot order
            ST_SPAWN_FIN:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = 1'b1;
                    slot_out_next  = SLOT_FIELD_W'(spawn_idx_reg);
                    side_out_next  = s;
                    count_out_next = COUNT_FIELD_W'(cur_len);
                    last_next      = 1'b1;
                    if (nf_hit_reg)
                    begin
                        fh_next[s] = nf_rd[SLOT_W-1:0];
                        he_next[s] = nf_rd[SLOT_W];
                    end
                    else if (fb_more)
                    begin
                        fh_next[s] = SLOT_W'(nxt_cnt);
                        he_next[s] = 1'b0;
                    end
                    else
                    begin
                        fh_next[s] = '0;
                        he_next[s] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            // retire, failed spawn, empty sweep and unused kinds
            ST_SINGLE:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = (cmd_reg.op == OP_RETIRE) && retire_hit;
                    slot_out_next  = (cmd_reg.op == OP_RETIRE) ? cmd_reg.slot : '0;
                    side_out_next  = s;
                    count_out_next = COUNT_FIELD_W'(cur_len);
                    last_next      = 1'b1;
                    if ((cmd_reg.op == OP_RETIRE) && retire_hit)
                    begin
                        alive_next[{s, SLOT_W'(cmd_reg.slot)}] = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            // walk: fetch the entry at the cursor
            ST_W_RD:
            begin
                if (i_reg < cur_len)
                begin
                    list_re    = 1'b1;
                    list_ra    = {s, i_reg[SLOT_W-1:0]};
                    state_next = ST_W_CHK;
                end
                else if (cur_len == '0)
                begin
                    state_next = ST_SINGLE;
                end
                else
                begin
                    i_next     = '0;
                    state_next = ST_E_RD;
                end
            end

            // walk: keep live slots, free dead ones and fetch the tail
            ST_W_CHK:
            begin
                if (alive_reg[idx_addr])
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = ST_W_RD;
                end
                else
                begin
                    list_re            = 1'b1;
                    list_ra            = {s, len_dec[SLOT_W-1:0]};
                    nf_we              = 1'b1;
                    nf_wa              = idx_addr;
                    nf_wd              = {cur_he, cur_fh};
                    nfv_next[idx_addr] = 1'b1;
                    fh_next[s]         = list_rd;
                    he_next[s]         = 1'b0;
                    len_next[s]        = len_dec;
                    state_next         = ST_W_MV;
                end
            end

            // walk: tail entry moves into the hole
            ST_W_MV:
            begin
                list_we    = 1'b1;
                list_wa    = {s, i_reg[SLOT_W-1:0]};
                list_wd    = list_rd;
                state_next = ST_W_RD;
            end

            // report: the compacted list holds the live slots in walk order
            ST_E_RD:
            begin
                list_re    = 1'b1;
                list_ra    = {s, i_reg[SLOT_W-1:0]};
                state_next = ST_E_OUT;
            end

            ST_E_OUT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = 1'b1;
                    slot_out_next  = SLOT_FIELD_W'(list_rd);
                    side_out_next  = s;
                    count_out_next = COUNT_FIELD_W'(cur_len);
                    last_next      = emit_last;
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = ST_E_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // capacity write rebuilds both pools
        if (cfg_we)
        begin
            cap_next[0] = cfg_caps[CNT_W-1:0];
            cap_next[1] = cfg_caps[2*CNT_W-1:CNT_W];
            fh_next[0]  = '0;
            fh_next[1]  = '0;
            he_next[0]  = (cfg_caps[CNT_W-1:0] == '0);
            he_next[1]  = (cfg_caps[2*CNT_W-1:CNT_W] == '0);
            len_next[0] = '0;
            len_next[1] = '0;
            alive_next  = '0;
            nfv_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg[0]    <= CAP_RST[CNT_W-1:0];
            cap_reg[1]    <= CAP_RST[2*CNT_W-1:CNT_W];
            fh_reg[0]     <= '0;
            fh_reg[1]     <= '0;
            he_reg[0]     <= (CAP_RST[CNT_W-1:0] == '0);
            he_reg[1]     <= (CAP_RST[2*CNT_W-1:CNT_W] == '0);
            len_reg[0]    <= '0;
            len_reg[1]    <= '0;
            alive_reg     <= '0;
            nfv_reg       <= '0;
            i_reg         <= '0;
            nf_hit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            fh_reg        <= fh_next;
            he_reg        <= he_next;
            len_reg       <= len_next;
            alive_reg     <= alive_next;
            nfv_reg       <= nfv_next;
            i_reg         <= i_next;
            nf_hit_reg    <= nf_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        spawn_idx_reg <= spawn_idx_next;
        ok_reg        <= ok_next;
        slot_out_reg  <= slot_out_next;
        side_out_reg  <= side_out_next;
        count_out_reg <= count_out_next;
        last_reg      <= last_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.ok           = ok_reg;
    assign rsp.slot_index   = slot_out_reg;
    assign rsp.pool_side    = side_out_reg;
    assign rsp.active_count = count_out_reg;
    assign rsp.last         = last_reg;

endmodule

`default_nettype wire
